// ===== sv/mrd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrd_pkg: shared types, constants and functions of the reply decoder
// Holds the reply view and result types, the status codes, the byte-wide
// parity fold and the altitude code conversion.
// ----------------------------------------------------------------------------
package mrd_pkg;

  // Widest reply that the decoder ever looks at, in bytes.
  localparam int unsigned REPLY_BYTES = 14;
  // The byte count saturates at this value.
  localparam logic [3:0]  COUNT_SAT   = 4'd15;
  // Mode S generator polynomial without its top bit.
  localparam logic [23:0] CRC_POLY    = 24'hFFF409;
  // Lengths and format numbers that the length check uses.
  localparam logic [3:0]  LEN_MODE_AC = 4'd2;
  localparam logic [3:0]  LEN_SHORT   = 4'd7;
  localparam logic [3:0]  LEN_LONG    = 4'd14;
  localparam logic [4:0]  DF_LONG_MIN = 5'd16;

  // Downlink formats handled by the decoder.
  localparam logic [4:0] DF_SURV_ALT_SHORT = 5'd0;
  localparam logic [4:0] DF_SURV_ALT       = 5'd4;
  localparam logic [4:0] DF_SURV_ID        = 5'd5;
  localparam logic [4:0] DF_ALL_CALL       = 5'd11;
  localparam logic [4:0] DF_ACAS_LONG      = 5'd16;
  localparam logic [4:0] DF_EXT_SQUITTER   = 5'd17;
  localparam logic [4:0] DF_COMM_B_ALT     = 5'd20;
  localparam logic [4:0] DF_COMM_B_ID      = 5'd21;

  // Airborne position type codes and the NUCp bases.
  localparam logic [4:0] TC_BARO_MIN = 5'd9;
  localparam logic [4:0] TC_BARO_MAX = 5'd18;
  localparam logic [4:0] TC_GNSS_MIN = 5'd20;
  localparam logic [4:0] TC_GNSS_MAX = 5'd21;
  localparam logic [4:0] NUC_BARO    = 5'd18;
  localparam logic [4:0] NUC_GNSS    = 5'd29;

  typedef enum logic [1:0] {
    STATUS_MODE_AC     = 2'd0,
    STATUS_MODE_S      = 2'd1,
    STATUS_BAD_LENGTH  = 2'd2,
    STATUS_UNSUPPORTED = 2'd3
  } status_e;

  // Complete reply as seen on its last byte.
  typedef struct packed {
    logic [REPLY_BYTES-1:0][7:0] bytes;
    logic [3:0]                  len;
    logic [23:0]                 crc;
  } reply_t;

  // One decode result.
  typedef struct packed {
    status_e            status;
    logic [4:0]         downlink_format;
    logic               valid_res;
    logic [23:0]        crc_syndrome;
    logic [23:0]        address;
    logic               address_present;
    logic signed [18:0] altitude_ft;
    logic               altitude_present;
    logic [3:0]         nuc_p;
    logic               odd_format;
    logic               even_format;
  } result_t;

  typedef struct packed {
    logic               ok;
    logic signed [18:0] alt;
  } alt_t;

  // Shift one byte, most significant bit first, into the remainder.
  function automatic logic [23:0] crc_fold(logic [23:0] r, logic [7:0] b);
    logic [23:0] x;
    x = r;
    for (int i = 7; i >= 0; i--) begin
      x = {x[22:0], b[i]} ^ (x[23] ? CRC_POLY : 24'h0);
    end
    return x;
  endfunction

  // 13-bit altitude code, Q-bit (25 ft) or Gillham (100 ft).
  function automatic alt_t alt13(logic [12:0] c);
    alt_t               r;
    logic [2:0]         h;
    logic [7:0]         f;
    logic [10:0]        n;
    logic signed [19:0] a;
    r.ok  = 1'b0;
    r.alt = '0;
    h     = '0;
    f     = '0;
    n     = {c[12:7], c[5], c[3:0]};
    a     = '0;
    if (c == 13'd0 || c[6]) begin
      r.ok = 1'b0;
    end else if (c[4]) begin
      a     = $signed({9'd0, n}) * 20'sd25 - 20'sd1000;
      r.ok  = 1'b1;
      r.alt = a[18:0];
    end else if ((c & 13'h1500) != 13'd0) begin
      // Hundreds from the C bits, in reflected binary.
      if (c[12]) h ^= 3'd7;
      if (c[10]) h ^= 3'd3;
      if (c[8])  h ^= 3'd1;
      if ((h & 3'd5) != 3'd0) h ^= 3'd5;
      // Five-hundreds from the D, A and B bits, in Gray code.
      if (c[2])  f ^= 8'hff;
      if (c[0])  f ^= 8'h7f;
      if (c[11]) f ^= 8'h3f;
      if (c[9])  f ^= 8'h1f;
      if (c[7])  f ^= 8'h0f;
      if (c[5])  f ^= 8'h07;
      if (c[3])  f ^= 8'h03;
      if (c[1])  f ^= 8'h01;
      if (h <= 3'd5) begin
        if (f[0]) h = 3'd6 - h;
        a = $signed({12'd0, f}) * 20'sd500 + $signed({17'd0, h}) * 20'sd100
            - 20'sd1300;
        if (a >= -20'sd1200) begin
          r.ok  = 1'b1;
          r.alt = a[18:0];
        end
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/mode_s_reply_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mode_s_reply_decoder: Mode A/C and Mode S downlink reply decoder
// Collects reply bytes, forms the parity residual and emits one decode
// for each reply.
// ----------------------------------------------------------------------------
// Usage:
//   Reply bytes arrive on the slave stream, first byte first, one byte per
//   transfer in s_axis_tdata[7:0]; s_axis_tlast marks the final byte.
//   Each reply gives exactly one result transfer on the master stream when
//   its last byte has been processed; other bytes give no result.
//   A byte is registered on arrival and processed from the input register,
//   where the remainder update and the whole decode are done by one level
//   of logic. The result register loads when the last byte is processed,
//   so a result passes the input register and then the result register
//   before it can be taken. One byte is accepted every cycle. Only a last
//   byte waits, and only while the result register holds an untaken result;
//   this single result register and the input register are the only stall
//   points, so a stalled receiver blocks the input one reply later.
//   Reset clears the byte count, the remainder and both valid flags; the
//   byte store needs no clearing since only bytes of the current reply
//   are read.
// ----------------------------------------------------------------------------
module mode_s_reply_decoder #(
  parameter int unsigned MAX_REPLY_BYTES = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [6:2] downlink_format, [7] valid_res, [31:8] crc_syndrome,
  // [55:32] address, [56] address_present, [75:57] altitude_ft,
  // [76] altitude_present, [80:77] nuc_p, [81] odd_format, [82] even_format,
  // [87:83] zero
  output logic [87:0] m_axis_tdata
);

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             in_last_q;
  logic             proc;
  logic             out_valid_q, out_valid_d;
  mrd_pkg::reply_t  reply;
  mrd_pkg::result_t result;
  mrd_pkg::result_t res_q;

  // A byte is processed unless it completes a reply and the result is blocked.
  assign proc          = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  mrd_capture #(
    .MAX_REPLY_BYTES(MAX_REPLY_BYTES)
  ) u_capture (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (proc),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .reply_o(reply)
  );

  mrd_decode #(
    .MAX_REPLY_BYTES(MAX_REPLY_BYTES)
  ) u_decode (
    .reply_i (reply),
    .result_o(result)
  );

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (proc && in_last_q) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && in_last_q) begin
      res_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0,
                          res_q.even_format,
                          res_q.odd_format,
                          res_q.nuc_p,
                          res_q.altitude_present,
                          res_q.altitude_ft,
                          res_q.address_present,
                          res_q.address,
                          res_q.crc_syndrome,
                          res_q.valid_res,
                          res_q.downlink_format,
                          res_q.status};

endmodule

// ===== sv/mrd_capture.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrd_capture: reply byte store, byte count and running parity remainder
// Stores each processed byte, counts it and folds it into the remainder,
// and presents the whole reply, current byte included, for decoding.
// ----------------------------------------------------------------------------
module mrd_capture #(
  parameter int unsigned MAX_REPLY_BYTES = 14
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [7:0]      byte_i,
  input  logic            last_i,
  output mrd_pkg::reply_t reply_o
);

  localparam int unsigned IDX_W = $clog2(MAX_REPLY_BYTES);

  logic [7:0]  store_q [MAX_REPLY_BYTES];
  logic [3:0]  count_q, count_d;
  logic [23:0] crc_q, crc_d;
  logic [23:0] crc_next;
  logic        store_wr;

  assign crc_next = mrd_pkg::crc_fold(crc_q, byte_i);
  assign store_wr = en_i && (count_q < 4'(MAX_REPLY_BYTES));

  // Count and remainder restart after the last byte of a reply.
  always_comb begin
    count_d = count_q;
    crc_d   = crc_q;
    if (en_i) begin
      if (last_i) begin
        count_d = '0;
        crc_d   = '0;
      end else begin
        count_d = (count_q == mrd_pkg::COUNT_SAT) ? count_q : count_q + 4'd1;
        crc_d   = crc_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      crc_q   <= '0;
    end else begin
      count_q <= count_d;
      crc_q   <= crc_d;
    end
  end

  // Byte store, written at the count.
  always_ff @(posedge clk_i) begin
    if (store_wr) begin
      store_q[count_q[IDX_W-1:0]] <= byte_i;
    end
  end

  // Reply view: the byte in process stands in for its slot.
  for (genvar i = 0; i < mrd_pkg::REPLY_BYTES; i++) begin : g_view
    if (i < MAX_REPLY_BYTES) begin : g_stored
      assign reply_o.bytes[i] = (count_q == 4'(i)) ? byte_i : store_q[i];
    end else begin : g_absent
      assign reply_o.bytes[i] = 8'h00;
    end
  end

  assign reply_o.len = (count_q == mrd_pkg::COUNT_SAT) ? count_q : count_q + 4'd1;
  assign reply_o.crc = crc_next;

endmodule

// ===== sv/mrd_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrd_decode: classification and field decode of one complete reply
// Checks length and format, selects the address, and decodes altitude,
// NUCp and the CPR format flag.
// ----------------------------------------------------------------------------
module mrd_decode #(
  parameter int unsigned MAX_REPLY_BYTES = 14
) (
  input  mrd_pkg::reply_t  reply_i,
  output mrd_pkg::result_t result_o
);

  logic [mrd_pkg::REPLY_BYTES-1:0][7:0] d;
  logic [4:0]    df;
  logic [4:0]    tc;
  logic [23:0]   icao;
  logic          len_bad;
  logic          df_ok;
  logic          pos_tc;
  mrd_pkg::alt_t alt_short;
  mrd_pkg::alt_t alt_ext;

  assign d    = reply_i.bytes;
  assign df   = d[0][7:3];
  assign tc   = d[4][7:3];
  assign icao = {d[1], d[2], d[3]};

  assign len_bad = (reply_i.len > 4'(MAX_REPLY_BYTES))
                || (df <  mrd_pkg::DF_LONG_MIN && reply_i.len != mrd_pkg::LEN_SHORT)
                || (df >= mrd_pkg::DF_LONG_MIN && reply_i.len != mrd_pkg::LEN_LONG);

  assign df_ok = (df == mrd_pkg::DF_SURV_ALT_SHORT) || (df == mrd_pkg::DF_SURV_ALT)
              || (df == mrd_pkg::DF_SURV_ID)        || (df == mrd_pkg::DF_ALL_CALL)
              || (df == mrd_pkg::DF_ACAS_LONG)      || (df == mrd_pkg::DF_EXT_SQUITTER)
              || (df == mrd_pkg::DF_COMM_B_ALT)     || (df == mrd_pkg::DF_COMM_B_ID);

  assign pos_tc = (tc >= mrd_pkg::TC_BARO_MIN && tc <= mrd_pkg::TC_BARO_MAX)
               || (tc >= mrd_pkg::TC_GNSS_MIN && tc <= mrd_pkg::TC_GNSS_MAX);

  // Altitude from the AC field, and from the squitter's position altitude.
  // The 12-bit squitter code gets a zero M bit inserted above its low six bits.
  assign alt_short = mrd_pkg::alt13({d[2][4:0], d[3]});
  assign alt_ext   = mrd_pkg::alt13({d[5][7:2], 1'b0, d[5][1:0], d[6][7:4]});

  // Result selection by length and downlink format.
  always_comb begin
    result_o        = '0;
    result_o.status = mrd_pkg::STATUS_MODE_AC;
    if (reply_i.len == mrd_pkg::LEN_MODE_AC) begin
      result_o.valid_res       = 1'b1;
      result_o.address         = {8'h00, d[0], d[1]};
      result_o.address_present = 1'b1;
    end else begin
      result_o.downlink_format = df;
      if (len_bad) begin
        result_o.status = mrd_pkg::STATUS_BAD_LENGTH;
      end else if (!df_ok) begin
        result_o.status = mrd_pkg::STATUS_UNSUPPORTED;
      end else begin
        result_o.status       = mrd_pkg::STATUS_MODE_S;
        result_o.crc_syndrome = reply_i.crc;
        unique case (df)
          mrd_pkg::DF_SURV_ALT_SHORT, mrd_pkg::DF_SURV_ALT,
          mrd_pkg::DF_ACAS_LONG, mrd_pkg::DF_COMM_B_ALT: begin
            result_o.valid_res        = 1'b1;
            result_o.address          = reply_i.crc;
            result_o.address_present  = 1'b1;
            result_o.altitude_present = alt_short.ok;
            result_o.altitude_ft      = alt_short.ok ? alt_short.alt : '0;
          end
          mrd_pkg::DF_SURV_ID, mrd_pkg::DF_COMM_B_ID: begin
            result_o.valid_res       = 1'b1;
            result_o.address         = reply_i.crc;
            result_o.address_present = 1'b1;
          end
          mrd_pkg::DF_ALL_CALL: begin
            // The low seven residual bits carry the interrogator code.
            if (reply_i.crc[23:7] == 17'd0) begin
              result_o.valid_res       = 1'b1;
              result_o.address         = icao;
              result_o.address_present = 1'b1;
            end
          end
          default: begin
            // Extended squitter: parity must be clean.
            if (reply_i.crc == 24'd0) begin
              result_o.valid_res       = 1'b1;
              result_o.address         = icao;
              result_o.address_present = 1'b1;
              if (pos_tc) begin
                result_o.nuc_p = (tc <= mrd_pkg::TC_BARO_MAX)
                               ? 4'(mrd_pkg::NUC_BARO - tc)
                               : 4'(mrd_pkg::NUC_GNSS - tc);
                result_o.odd_format       = d[6][2];
                result_o.even_format      = !d[6][2];
                result_o.altitude_present = alt_ext.ok;
                result_o.altitude_ft      = alt_ext.ok ? alt_ext.alt : '0;
                // An empty CPR latitude or longitude marks the position unusable.
                if ((d[7] == 8'h00 && d[8][6:0] == 7'h00)
                    || (d[9] == 8'h00 && d[10] == 8'h00)) begin
                  result_o.valid_res = 1'b0;
                end
              end
            end
          end
        endcase
      end
    end
  end

endmodule
